// ----- sv/fm_phase_discriminator_assert.svh -----
// fm_phase_discriminator_assert.svh: assertion macros for the phase discriminator
// no dependencies; included by the modules that carry assertions
`ifndef FM_PHASE_DISCRIMINATOR_ASSERT_SVH
`define FM_PHASE_DISCRIMINATOR_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define FMPD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fmpd assertion failed");
// next-cycle implication
`define FMPD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fmpd assertion failed");
`else
`define FMPD_ASSERT_IMP(label, clk, rst, ante, cons)
`define FMPD_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- sv/fmpd_pkg.sv -----
// fmpd_pkg: widths, codes and shared types of the fm phase discriminator
// no dependencies; used by fmpd_div_unit and fm_phase_discriminator
`timescale 1ns / 1ps
`default_nettype none

package fmpd_pkg;

   // sample and arithmetic widths
   localparam int SAMPLE_WIDTH = 16;
   localparam int DEN_WIDTH    = SAMPLE_WIDTH + 2;
   localparam int QUOT_WIDTH   = 15;
   localparam int NUM_WIDTH    = DEN_WIDTH + QUOT_WIDTH - 1;
   localparam int COUNT_WIDTH  = $clog2(QUOT_WIDTH);
   localparam int ANGLE_WIDTH  = 16;
   localparam int ANGLE_SHIFT  = 13;

   // fixed point angle constants, pi = 16384
   localparam int PI_ANGLE = 16384;

   // input op codes (carried in tuser)
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_SYNC   = 1'b1;

   // register file
   localparam int CSR_ADDR_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_INDEX_WIDTH = CSR_ADDR_WIDTH - 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IDX_EMIT_RAW = '0;

   // divider status back to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// ----- sv/fmpd_div_unit.sv -----
// fmpd_div_unit: shared restoring divider, one quotient bit per cycle
// depends on fmpd_pkg and fm_phase_discriminator_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "fm_phase_discriminator_assert.svh"

module fmpd_div_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [fmpd_pkg::NUM_WIDTH-1:0]   numerator,
   input  wire logic [fmpd_pkg::DEN_WIDTH-1:0]   denominator,
   output fmpd_pkg::div_status_type              status,
   output logic      [fmpd_pkg::QUOT_WIDTH-1:0]  quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [fmpd_pkg::COUNT_WIDTH-1:0]  count_ff, count_in;
   logic [fmpd_pkg::NUM_WIDTH-1:0]    rem_ff, rem_in;
   logic [fmpd_pkg::NUM_WIDTH-1:0]    dsh_ff, dsh_in;
   logic [fmpd_pkg::QUOT_WIDTH-1:0]   quot_ff, quot_in;
   logic                              fits;

   // trial subtract of the shifted divisor
   assign fits = (rem_ff >= dsh_ff);

   // iteration control
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      quot_in  = quot_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = fmpd_pkg::COUNT_WIDTH'(fmpd_pkg::QUOT_WIDTH - 1);
         rem_in   = numerator;
         dsh_in   = {denominator, {(fmpd_pkg::QUOT_WIDTH-1){1'b0}}};
         quot_in  = '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsh_ff;
         end
         quot_in = {quot_ff[fmpd_pkg::QUOT_WIDTH-2:0], fits};
         dsh_in  = dsh_ff >> 1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quot_ff;

   `FMPD_ASSERT_IMP(a_no_start_busy, clock, reset, start, !busy_ff)
   `FMPD_ASSERT_NXT(a_start_loads, clock, reset, start, busy_ff && count_ff == fmpd_pkg::COUNT_WIDTH'(fmpd_pkg::QUOT_WIDTH - 1))
   `FMPD_ASSERT_IMP(a_done_idle, clock, reset, done_ff, !busy_ff)

endmodule

`default_nettype wire

// ----- sv/fm_phase_discriminator.sv -----
// fm_phase_discriminator: a sample runs S_PREP, S_DIVIDE, then S_FINISH sets rsp_tvalid
// a new sample is taken only back in S_IDLE, after the 15-step shared restoring divider
// a sync beat gives no result; req_tready is high only when idle
// the result register lets a new sample start while the last result waits
// synchronous active-high reset clears the stored angle, the register and all control
`timescale 1ns / 1ps
`default_nettype none

`include "fm_phase_discriminator_assert.svh"

module fm_phase_discriminator (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // sample stream
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [2*fmpd_pkg::SAMPLE_WIDTH-1:0]   req_tdata,  // i_sample, q_sample
   input  wire logic [0:0]                            req_tuser,  // op
   // result stream
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic      [fmpd_pkg::ANGLE_WIDTH-1:0]      rsp_tdata,  // phase_value
   // register port
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [fmpd_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  wire logic [fmpd_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic      [fmpd_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                       csr_pready
);

   localparam int SW = fmpd_pkg::SAMPLE_WIDTH;
   localparam int AW = fmpd_pkg::ANGLE_WIDTH;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_PREP   = 2'd1;
   localparam logic [1:0] S_DIVIDE = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0]                           state_ff, state_in;
   logic                                 emit_raw_ff, emit_raw_in;
   logic signed [AW-1:0]                 prev_ff, prev_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]                        rsp_data_ff, rsp_data_in;
   logic [SW-1:0]                        mag_y_ff, mag_y_in;
   logic [SW-1:0]                        mag_x_ff, mag_x_in;
   logic                                 y_neg_ff, y_neg_in;
   logic                                 x_neg_ff, x_neg_in;

   logic [SW-1:0]                        y_raw, x_raw;
   logic [SW:0]                          ay, ax;
   logic [fmpd_pkg::DEN_WIDTH-1:0]       den, msum;
   logic [fmpd_pkg::NUM_WIDTH-1:0]       num;
   logic                                 div_start;
   fmpd_pkg::div_status_type             div_status;
   logic [fmpd_pkg::QUOT_WIDTH-1:0]      div_quotient;
   logic [fmpd_pkg::QUOT_WIDTH-1:0]      angle_mag;
   logic signed [AW-1:0]                 angle;
   logic signed [AW:0]                   diff;
   logic [AW-1:0]                        diff_sat;
   logic [AW-1:0]                        result;
   logic                                 csr_wr;
   logic [fmpd_pkg::CSR_INDEX_WIDTH-1:0] csr_index;

   // register port
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[fmpd_pkg::CSR_ADDR_WIDTH-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign emit_raw_in = (csr_wr && csr_index == fmpd_pkg::CSR_IDX_EMIT_RAW) ?
                        csr_pwdata[0] : emit_raw_ff;
   assign csr_prdata = (csr_index == fmpd_pkg::CSR_IDX_EMIT_RAW) ?
                       fmpd_pkg::CSR_DATA_WIDTH'(emit_raw_ff) : '0;

   // operand magnitudes; i is the y argument, q the x argument
   assign y_raw = req_tdata[SW-1:0];
   assign x_raw = req_tdata[2*SW-1:SW];

   // doubled magnitudes, epsilon folded into the low bit of ay
   assign ay   = {mag_y_ff, 1'b1};
   assign ax   = {mag_x_ff, 1'b0};
   assign den  = fmpd_pkg::DEN_WIDTH'(ay) + fmpd_pkg::DEN_WIDTH'(ax);
   assign msum = x_neg_ff ? (fmpd_pkg::DEN_WIDTH'(ay) + {ax, 1'b0}) :
                            fmpd_pkg::DEN_WIDTH'(ay);
   assign num  = fmpd_pkg::NUM_WIDTH'({msum, {fmpd_pkg::ANGLE_SHIFT{1'b0}}}) +
                 fmpd_pkg::NUM_WIDTH'(den >> 1);

   fmpd_div_unit u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (num),
      .denominator (den),
      .status      (div_status),
      .quotient    (div_quotient)
   );

   // signed angle, difference and saturation
   assign angle_mag = (div_quotient > fmpd_pkg::QUOT_WIDTH'(fmpd_pkg::PI_ANGLE)) ?
                      fmpd_pkg::QUOT_WIDTH'(fmpd_pkg::PI_ANGLE) : div_quotient;
   assign angle = y_neg_ff ? -$signed(AW'(angle_mag)) : $signed(AW'(angle_mag));
   assign diff  = $signed({angle[AW-1], angle}) - $signed({prev_ff[AW-1], prev_ff});

   always_comb begin
      if (!diff[AW] && diff[AW-1]) begin
         diff_sat = {1'b0, {(AW-1){1'b1}}};
      end else if (diff[AW] && !diff[AW-1]) begin
         diff_sat = {1'b1, {(AW-1){1'b0}}};
      end else begin
         diff_sat = diff[AW-1:0];
      end
   end

   assign result = emit_raw_ff ? angle : diff_sat;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      prev_in      = prev_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mag_y_in     = mag_y_ff;
      mag_x_in     = mag_x_ff;
      y_neg_in     = y_neg_ff;
      x_neg_in     = x_neg_ff;
      div_start    = 1'b0;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser[0] == fmpd_pkg::OP_SYNC) begin
                  prev_in = '0;
               end else begin
                  y_neg_in = y_raw[SW-1];
                  x_neg_in = x_raw[SW-1];
                  mag_y_in = y_raw[SW-1] ? (~y_raw + 1'b1) : y_raw;
                  mag_x_in = x_raw[SW-1] ? (~x_raw + 1'b1) : x_raw;
                  state_in = S_PREP;
               end
            end
         end
         S_PREP: begin
            div_start = 1'b1;
            state_in  = S_DIVIDE;
         end
         S_DIVIDE: begin
            if (div_status.done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result;
               prev_in      = angle;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         emit_raw_ff  <= 1'b0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         emit_raw_ff  <= emit_raw_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      mag_y_ff    <= mag_y_in;
      mag_x_ff    <= mag_x_in;
      y_neg_ff    <= y_neg_in;
      x_neg_ff    <= x_neg_in;
   end

   `FMPD_ASSERT_IMP(a_quot_range, clock, reset, state_ff == S_FINISH, div_quotient <= fmpd_pkg::QUOT_WIDTH'(fmpd_pkg::PI_ANGLE))
   `FMPD_ASSERT_NXT(a_sample_starts, clock, reset, req_tvalid && req_tready && req_tuser[0] == fmpd_pkg::OP_SAMPLE, state_ff == S_PREP)
   `FMPD_ASSERT_IMP(a_done_in_divide, clock, reset, div_status.done, state_ff == S_DIVIDE)

endmodule

`default_nettype wire

// ----- tb/fmpd_phase_checker.sv -----
// fmpd_phase_checker: watches the sample, result and register ports of the phase discriminator
// keeps its own angle state, predicts every phase value and compares it beat by beat
// depends on fmpd_pkg for widths, op codes and register indexes
`timescale 1ns / 1ps

module fmpd_phase_checker (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      req_tvalid,
   input  wire logic                                      req_tready,
   input  wire logic [2*fmpd_pkg::SAMPLE_WIDTH-1:0]       req_tdata,
   input  wire logic [0:0]                                req_tuser,
   input  wire logic                                      rsp_tvalid,
   input  wire logic                                      rsp_tready,
   input  wire logic [fmpd_pkg::ANGLE_WIDTH-1:0]          rsp_tdata,
   input  wire logic                                      csr_psel,
   input  wire logic                                      csr_penable,
   input  wire logic                                      csr_pwrite,
   input  wire logic [fmpd_pkg::CSR_ADDR_WIDTH-1:0]       csr_paddr,
   input  wire logic [fmpd_pkg::CSR_DATA_WIDTH-1:0]       csr_pwdata,
   input  wire logic [fmpd_pkg::CSR_DATA_WIDTH-1:0]       csr_prdata,
   input  wire logic                                      csr_pready,
   output int                                             mismatch_count,
   output int                                             pending_count
);

   // sample beat layout, i_sample in the low half
   typedef struct packed {
      logic signed [fmpd_pkg::SAMPLE_WIDTH-1:0] q_sample;
      logic signed [fmpd_pkg::SAMPLE_WIDTH-1:0] i_sample;
   } iq_beat_type;

   logic signed [fmpd_pkg::ANGLE_WIDTH-1:0] expected_phase[$];
   logic signed [fmpd_pkg::ANGLE_WIDTH-1:0] prev_angle;
   logic                                    raw_mode;

   // two-segment arctangent, y = i, x = q, rounded with halves going up
   function automatic logic signed [fmpd_pkg::ANGLE_WIDTH-1:0] predict_angle(
      input logic signed [fmpd_pkg::SAMPLE_WIDTH-1:0] y,
      input logic signed [fmpd_pkg::SAMPLE_WIDTH-1:0] x
   );
      longint sy, sx, ay, ax, den, num, a;
      sy = y;
      sx = x;
      // the +1 on |y| keeps the denominator away from zero
      ay = 2 * ((sy < 0) ? -sy : sy) + 1;
      ax = 2 * ((sx < 0) ? -sx : sx);
      den = ax + ay;
      num = (sx >= 0) ? 8192 * ay : 8192 * (ay + 2 * ax);
      a = (num + den / 2) / den;
      if (a > fmpd_pkg::PI_ANGLE)
         a = fmpd_pkg::PI_ANGLE;
      if (sy < 0)
         a = -a;
      return fmpd_pkg::ANGLE_WIDTH'(a);
   endfunction

   // difference from the kept angle, clipped to the output range
   function automatic logic signed [fmpd_pkg::ANGLE_WIDTH-1:0] predict_phase(
      input logic signed [fmpd_pkg::ANGLE_WIDTH-1:0] angle
   );
      int diff;
      if (raw_mode)
         return angle;
      diff = int'(angle) - int'(prev_angle);
      if (diff > 32767)
         diff = 32767;
      if (diff < -32768)
         diff = -32768;
      return fmpd_pkg::ANGLE_WIDTH'(diff);
   endfunction

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
      prev_angle     = '0;
      raw_mode       = 1'b0;
   end

   always @(posedge clock) begin : monitor
      iq_beat_type                             beat;
      logic signed [fmpd_pkg::ANGLE_WIDTH-1:0] angle;
      logic signed [fmpd_pkg::ANGLE_WIDTH-1:0] want;
      if (reset) begin
         prev_angle = '0;
         raw_mode   = 1'b0;
         expected_phase.delete();
      end else begin
         // register port, reads checked against the shadow copy
         if (csr_psel && csr_penable && csr_pready &&
             csr_paddr[fmpd_pkg::CSR_ADDR_WIDTH-1:2] == fmpd_pkg::CSR_IDX_EMIT_RAW) begin
            if (csr_pwrite) begin
               raw_mode = csr_pwdata[0];
            end else if (csr_prdata !== fmpd_pkg::CSR_DATA_WIDTH'(raw_mode)) begin
               $display("%0t: register read mismatch: expected %0h, got %0h",
                        $time, fmpd_pkg::CSR_DATA_WIDTH'(raw_mode), csr_prdata);
               mismatch_count++;
            end
         end

         // result beat against the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            if (expected_phase.size() == 0) begin
               $display("%0t: unexpected result beat: expected none, got %0d",
                        $time, $signed(rsp_tdata));
               mismatch_count++;
            end else begin
               want = expected_phase.pop_front();
               if (rsp_tdata !== want) begin
                  $display("%0t: phase_value mismatch: expected %0d, got %0d",
                           $time, want, $signed(rsp_tdata));
                  mismatch_count++;
               end
            end
         end

         // sample or sync beat
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == fmpd_pkg::OP_SYNC) begin
               prev_angle = '0;
            end else begin
               beat  = req_tdata;
               angle = predict_angle(beat.i_sample, beat.q_sample);
               expected_phase.push_back(predict_phase(angle));
               prev_angle = angle;
            end
         end
      end
      pending_count = expected_phase.size();
   end

endmodule

// ----- tb/tb_top.sv -----
// tb_top: stimulus and verdict for the fm phase discriminator
// drives directed and random sample/sync beats, register writes and back-pressure
// depends on fmpd_pkg, fm_phase_discriminator and fmpd_phase_checker
`timescale 1ns / 1ps

module tb_top;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int RANDOM_ITEMS   = 228;
   localparam int SW             = fmpd_pkg::SAMPLE_WIDTH;
   localparam int AD             = fmpd_pkg::CSR_ADDR_WIDTH;
   localparam int DW             = fmpd_pkg::CSR_DATA_WIDTH;
   localparam logic [AD-1:0] ADDR_EMIT_RAW = {fmpd_pkg::CSR_IDX_EMIT_RAW, 2'b00};
   localparam logic [AD-1:0] ADDR_UNMAPPED = 3'd4;
   localparam logic [SW-1:0] S_MAX  = {1'b0, {(SW-1){1'b1}}};
   localparam logic [SW-1:0] S_MIN  = {1'b1, {(SW-1){1'b0}}};
   localparam logic [SW-1:0] S_ZERO = '0;
   localparam logic [SW-1:0] S_ONE  = 1;
   localparam logic [SW-1:0] S_NEG1 = '1;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [2*SW-1:0]                    req_tdata = '0;  // i_sample, q_sample
   logic [0:0]                         req_tuser = fmpd_pkg::OP_SAMPLE;  // op
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [fmpd_pkg::ANGLE_WIDTH-1:0]   rsp_tdata;  // phase_value
   logic                               csr_psel = 1'b0;
   logic                               csr_penable = 1'b0;
   logic                               csr_pwrite = 1'b0;
   logic [AD-1:0]                      csr_paddr = '0;
   logic [DW-1:0]                      csr_pwdata = '0;
   logic [DW-1:0]                      csr_prdata;
   logic                               csr_pready;

   int mismatch_count;
   int pending_count;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int quiet_cycles = 0;

   fm_phase_discriminator uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   fmpd_phase_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // result back-pressure
   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog on cycles with no beat on any port
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** fm_phase_discriminator: FAILED **");
         $finish;
      end
   end

   // one beat on the sample port, entered and left at a falling edge
   task automatic send_beat(input logic op, input logic [SW-1:0] i_val,
                            input logic [SW-1:0] q_val);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {q_val, i_val};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // setup then access phase on the register port
   task automatic csr_access(input logic write, input logic [AD-1:0] addr,
                             input logic [DW-1:0] data);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = write;
      csr_paddr   = addr;
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // hold the sender until every result is back and the block has gone quiet
   task automatic drain();
      req_tvalid = 1'b0;
      wait (pending_count == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // mode switch with junk in the upper bits, a write the block must ignore, and a read back
   task automatic set_raw_mode(input logic raw);
      csr_access(1'b1, ADDR_EMIT_RAW, {$urandom} & ~32'd1 | 32'(raw));
      csr_access(1'b1, ADDR_UNMAPPED, $urandom);
      csr_access(1'b0, ADDR_EMIT_RAW, '0);
   endtask

   function automatic logic [SW-1:0] pick_sample();
      int sel;
      sel = $urandom_range(99);
      if (sel < 60)
         return SW'($urandom);
      if (sel < 85) begin
         case ($urandom_range(4))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return S_MIN + S_ONE;
            3:       return S_NEG1;
            default: return S_ZERO;
         endcase
      end
      return SW'(int'($urandom_range(8)) - 4);
   endfunction

   task automatic run_directed();
      // zero sample, then a sync with junk data
      send_beat(fmpd_pkg::OP_SAMPLE, S_ZERO, S_ZERO);
      send_beat(fmpd_pkg::OP_SYNC, S_MAX, S_MIN);
      // corners of the sample range
      send_beat(fmpd_pkg::OP_SAMPLE, S_MAX, S_MAX);
      send_beat(fmpd_pkg::OP_SAMPLE, S_MIN, S_MIN);
      send_beat(fmpd_pkg::OP_SAMPLE, S_MAX, S_MIN);
      send_beat(fmpd_pkg::OP_SAMPLE, S_MIN, S_MAX);
      send_beat(fmpd_pkg::OP_SAMPLE, S_ZERO, S_MAX);
      send_beat(fmpd_pkg::OP_SAMPLE, S_ZERO, S_MIN);
      // -pi then +pi: full negative swing, then +2pi clipped
      send_beat(fmpd_pkg::OP_SAMPLE, S_NEG1, S_MIN);
      send_beat(fmpd_pkg::OP_SAMPLE, S_ZERO, S_MIN);
      send_beat(fmpd_pkg::OP_SAMPLE, S_NEG1, S_ZERO);
      send_beat(fmpd_pkg::OP_SAMPLE, S_ONE, S_NEG1);
      send_beat(fmpd_pkg::OP_SAMPLE, S_NEG1, S_ONE);
      send_beat(fmpd_pkg::OP_SYNC, S_ZERO, S_ZERO);
      send_beat(fmpd_pkg::OP_SAMPLE, S_MIN, S_ZERO);
      send_beat(fmpd_pkg::OP_SAMPLE, S_MAX, S_ZERO);
      send_beat(fmpd_pkg::OP_SAMPLE, S_ZERO, S_ONE);
      send_beat(fmpd_pkg::OP_SAMPLE, S_MIN, S_NEG1);
      // absolute angles
      drain();
      set_raw_mode(1'b1);
      send_beat(fmpd_pkg::OP_SAMPLE, S_ZERO, S_ZERO);
      send_beat(fmpd_pkg::OP_SAMPLE, S_NEG1, S_MIN);
      send_beat(fmpd_pkg::OP_SAMPLE, S_ZERO, S_MIN);
      send_beat(fmpd_pkg::OP_SYNC, S_NEG1, S_NEG1);
      send_beat(fmpd_pkg::OP_SAMPLE, S_MAX, S_MIN);
      drain();
   endtask

   task automatic run_random(input int count);
      logic op;
      for (int n = 0; n < count; n++) begin
         op = ($urandom_range(99) < 4) ? fmpd_pkg::OP_SYNC : fmpd_pkg::OP_SAMPLE;
         send_beat(op, pick_sample(), pick_sample());
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      set_raw_mode(1'b0);
      run_directed();

      // idle mixes: none, sender, receiver, both
      for (int mode = 0; mode < 4; mode++) begin
         send_idle_pct  = (mode == 1 || mode == 3) ? ((mode == 3) ? 22 : 69) : 0;
         recv_stall_pct = (mode == 2 || mode == 3) ? ((mode == 3) ? 22 : 69) : 0;
         for (int raw = 0; raw < 2; raw++) begin
            set_raw_mode(raw[0]);
            run_random(RANDOM_ITEMS);
            drain();
         end
      end

      recv_stall_pct = 0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** fm_phase_discriminator: PASSED **");
      end else begin
         $display("** fm_phase_discriminator: FAILED **");
      end
      $finish;
   end

endmodule
